/* rtl/core/mwg_pkg.sv */
package mwg_pkg;

    localparam int PHASE_BITS   = 32;
    localparam int FRAC_BITS    = 12;
    localparam int TABLE_POINTS = 91;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int WAVE_TYPE_W = 3;
    localparam int STEP_W      = 32;
    localparam int BIAS_W      = 16;
    localparam int AMP_W       = 16;
    localparam int NOISE_W     = 32;
    localparam int SAMPLE_W    = 24;

    localparam int WAVE_W  = FRAC_BITS + 2;
    localparam int DEG_W   = PHASE_BITS + 9;
    localparam int IDX_W   = $clog2(TABLE_POINTS);
    localparam int TBL_W   = 16;
    localparam int TBL_FRAC_W = 15;
    localparam int INTERP_W = 16;
    localparam int SUM_W   = BIAS_W + 1;
    localparam int PROD_W  = SUM_W + AMP_W + 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [NOISE_W-1:0] NOISE_DEFAULT = 32'd2463534242;
    localparam logic [STEP_W-1:0]  STEP_RESET    = 32'd42949673;

    localparam logic [DEG_W-1:0] DEG_MULT = DEG_W'(360);
    localparam logic [DEG_W-1:0] DEG_180  = DEG_W'(180) << PHASE_BITS;
    localparam logic [DEG_W-1:0] DEG_90   = DEG_W'(90) << PHASE_BITS;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_POINTS - 1);

    localparam logic signed [WAVE_W:0] WAVE_ONE = (WAVE_W + 1)'(1) << FRAC_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WAVE_TYPE  = 3'd0,
        CFG_PHASE_STEP = 3'd1,
        CFG_BIAS       = 3'd2,
        CFG_HALF_AMP   = 3'd3,
        CFG_SEED       = 3'd4
    } t_cfg_idx;

    typedef enum logic [WAVE_TYPE_W-1:0] {
        WAVE_SINE     = 3'd0,
        WAVE_TRIANGLE = 3'd1,
        WAVE_SAW      = 3'd2,
        WAVE_INV_SAW  = 3'd3,
        WAVE_SQUARE   = 3'd4,
        WAVE_NOISE    = 3'd5
    } t_wave;

    typedef struct packed {
        logic [WAVE_TYPE_W-1:0] wave_type;
        logic [BIAS_W-1:0]      bias;
        logic [AMP_W-1:0]       half_amp;
    } t_cfg;

    typedef struct packed {
        logic [PHASE_BITS-1:0] phase;
        logic [NOISE_W-1:0]    noise;
    } t_item;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } t_q_status;

    localparam logic [TBL_W-1:0] QUARTER_SINE [0:TABLE_POINTS-1] = '{
        16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,
        16'd2856,  16'd3425,  16'd3993,  16'd4560,  16'd5126,
        16'd5690,  16'd6252,  16'd6813,  16'd7371,  16'd7927,
        16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668,
        16'd11207, 16'd11743, 16'd12275, 16'd12803, 16'd13328,
        16'd13848, 16'd14365, 16'd14876, 16'd15384, 16'd15886,
        16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
        16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622,
        16'd21063, 16'd21498, 16'd21926, 16'd22348, 16'd22763,
        16'd23170, 16'd23571, 16'd23965, 16'd24351, 16'd24730,
        16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510,
        16'd26842, 16'd27166, 16'd27482, 16'd27789, 16'd28088,
        16'd28378, 16'd28660, 16'd28932, 16'd29197, 16'd29452,
        16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
        16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499,
        16'd31651, 16'd31795, 16'd31928, 16'd32052, 16'd32166,
        16'd32270, 16'd32365, 16'd32449, 16'd32524, 16'd32588,
        16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763,
        16'd32768
    };

    function automatic logic [NOISE_W-1:0] xorshift(input logic [NOISE_W-1:0] s);
        logic [NOISE_W-1:0] x;
        x = s;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x;
    endfunction

endpackage

/* rtl/core/mwg_front.sv */
module mwg_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [mwg_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mwg_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_restart,
    input  mwg_pkg::t_q_status                 i_q_status,
    output logic                               o_push,
    output mwg_pkg::t_item                     o_item,
    output mwg_pkg::t_cfg                      o_cfg
);

    mwg_pkg::t_cfg                           r_cfg;
    logic [mwg_pkg::STEP_W-1:0]              r_step;
    logic [mwg_pkg::PHASE_BITS-1:0]          r_phase;
    logic [mwg_pkg::NOISE_W-1:0]             r_noise;

    logic                                    accept;
    logic [mwg_pkg::PHASE_BITS-1:0]          phase_cur;
    logic [mwg_pkg::STEP_W+mwg_pkg::PHASE_BITS-1:0] step_wide;
    logic [mwg_pkg::PHASE_BITS-1:0]          step;
    logic [mwg_pkg::NOISE_W-1:0]             noise_next;

    assign o_in_ready = !i_q_status.full;
    assign accept     = i_in_valid && !i_q_status.full;
    assign o_push     = accept;

    assign phase_cur  = i_restart ? '0 : r_phase;
    // The 32-bit step is rescaled to the accumulator width.
    assign step_wide  = {r_step, {mwg_pkg::PHASE_BITS{1'b0}}} >> mwg_pkg::STEP_W;
    assign step       = step_wide[mwg_pkg::PHASE_BITS-1:0];
    assign noise_next = mwg_pkg::xorshift(r_noise);

    assign o_item.phase = phase_cur;
    assign o_item.noise = noise_next;
    assign o_cfg        = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wave_type <= mwg_pkg::WAVE_SINE;
            r_cfg.bias      <= '0;
            r_cfg.half_amp  <= '0;
            r_step          <= mwg_pkg::STEP_RESET;
            r_phase         <= '0;
            r_noise         <= mwg_pkg::NOISE_DEFAULT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mwg_pkg::CFG_WAVE_TYPE: begin
                    r_cfg.wave_type <= i_cfg_data[mwg_pkg::WAVE_TYPE_W-1:0];
                    r_phase         <= '0;
                end
                mwg_pkg::CFG_PHASE_STEP: begin
                    r_step <= i_cfg_data[mwg_pkg::STEP_W-1:0];
                end
                mwg_pkg::CFG_BIAS: begin
                    r_cfg.bias <= i_cfg_data[mwg_pkg::BIAS_W-1:0];
                end
                mwg_pkg::CFG_HALF_AMP: begin
                    r_cfg.half_amp <= i_cfg_data[mwg_pkg::AMP_W-1:0];
                end
                mwg_pkg::CFG_SEED: begin
                    if (i_cfg_data[mwg_pkg::NOISE_W-1:0] == '0) begin
                        r_noise <= mwg_pkg::NOISE_DEFAULT;
                    end else begin
                        r_noise <= i_cfg_data[mwg_pkg::NOISE_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end else if (accept) begin
            r_phase <= phase_cur + step;
            if (r_cfg.wave_type == mwg_pkg::WAVE_NOISE) begin
                r_noise <= noise_next;
            end
        end
    end

endmodule

/* rtl/core/mwg_queue.sv */
module mwg_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  mwg_pkg::t_item     i_item,
    input  logic               i_pop,
    output mwg_pkg::t_item     o_item,
    output mwg_pkg::t_q_status o_status
);

    mwg_pkg::t_item                r_mem [mwg_pkg::QUEUE_DEPTH];
    logic [mwg_pkg::QPTR_W-1:0]    r_wr;
    logic [mwg_pkg::QPTR_W-1:0]    r_rd;
    logic [mwg_pkg::QCNT_W-1:0]    r_count;

    assign o_item          = r_mem[r_rd];
    assign o_status.count  = r_count;
    assign o_status.full   = (r_count == mwg_pkg::QCNT_W'(mwg_pkg::QUEUE_DEPTH));
    assign o_status.empty  = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + mwg_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + mwg_pkg::QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + mwg_pkg::QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - mwg_pkg::QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

/* rtl/core/mwg_back.sv */
module mwg_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  mwg_pkg::t_cfg                         i_cfg,
    input  mwg_pkg::t_item                        i_item,
    input  mwg_pkg::t_q_status                    i_q_status,
    output logic                                  o_pop,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [mwg_pkg::SAMPLE_W-1:0]   o_sample
);

    localparam int PB = mwg_pkg::PHASE_BITS;
    localparam int FB = mwg_pkg::FRAC_BITS;
    localparam int WW = mwg_pkg::WAVE_W;

    logic                                en;

    // Stage 1: degree scaling and the non-sine waves.
    logic                                r1_valid;
    logic [mwg_pkg::DEG_W-1:0]           r1_deg;
    logic signed [WW-1:0]                r1_wave;
    logic [mwg_pkg::DEG_W-1:0]           deg;
    logic [PB+1:0]                       ph4;
    logic [PB+1:0]                       tri_sh;
    logic signed [WW:0]                  tri_x;
    logic signed [WW:0]                  tri_w;
    logic signed [WW:0]                  saw_w;
    logic signed [WW:0]                  sq_w;
    logic signed [WW:0]                  noise_w;
    logic signed [WW:0]                  wave1;

    // Stage 2: folding and table reads.
    logic                                r2_valid;
    logic                                r2_neg;
    logic                                r2_full;
    logic [mwg_pkg::TBL_W-1:0]           r2_lo;
    logic [mwg_pkg::TBL_W-1:0]           r2_diff;
    logic [mwg_pkg::INTERP_W-1:0]        r2_frac;
    logic signed [WW-1:0]                r2_wave;
    logic                                neg;
    logic [mwg_pkg::DEG_W-1:0]           deg_h;
    logic [mwg_pkg::DEG_W-1:0]           deg_q;
    logic [mwg_pkg::IDX_W-1:0]           idx;
    logic [mwg_pkg::IDX_W-1:0]           idx_hi;
    logic                                full;
    logic [mwg_pkg::TBL_W-1:0]           tbl_lo;
    logic [mwg_pkg::TBL_W-1:0]           tbl_hi;

    // Stage 3: interpolation and wave select.
    logic                                r3_valid;
    logic signed [WW-1:0]                r3_wave;
    logic [2*mwg_pkg::TBL_W-1:0]         interp_p;
    logic [mwg_pkg::TBL_W-1:0]           interp;
    logic [mwg_pkg::TBL_W-1:0]           sine_val;
    logic [mwg_pkg::TBL_W-1:0]           sine_sh;
    logic signed [WW-1:0]                sine_mag;
    logic signed [WW-1:0]                wave3;

    // Output stage: bias, gain and floor scaling.
    logic                                r_out_valid;
    logic signed [mwg_pkg::SAMPLE_W-1:0] r_sample;
    logic                                active;
    logic signed [mwg_pkg::SUM_W-1:0]    sum;
    logic signed [mwg_pkg::PROD_W-1:0]   prod;
    logic signed [mwg_pkg::PROD_W-1:0]   prod_sh;

    assign en          = !r_out_valid || i_out_ready;
    assign o_pop       = en && !i_q_status.empty;
    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;

    always_comb begin
        deg     = mwg_pkg::DEG_W'(i_item.phase) * mwg_pkg::DEG_MULT;
        ph4     = {i_item.phase, 2'b00};
        tri_sh  = ph4 >> (PB - FB);
        tri_x   = $signed({1'b0, tri_sh[WW-1:0]});
        if (i_item.phase[PB-1:PB-2] == 2'b00) begin
            tri_w = tri_x;
        end else if (i_item.phase[PB-1:PB-2] != 2'b11) begin
            tri_w = (mwg_pkg::WAVE_ONE <<< 1) - tri_x;
        end else begin
            tri_w = tri_x - (mwg_pkg::WAVE_ONE <<< 2);
        end
        saw_w   = $signed({3'b000, i_item.phase[PB-1:PB-FB]});
        sq_w    = i_item.phase[PB-1] ? -mwg_pkg::WAVE_ONE : mwg_pkg::WAVE_ONE;
        noise_w = $signed({2'b00, i_item.noise[mwg_pkg::NOISE_W-1:31-FB]})
                  - mwg_pkg::WAVE_ONE;
        case (i_cfg.wave_type)
            mwg_pkg::WAVE_TRIANGLE: wave1 = tri_w;
            mwg_pkg::WAVE_SAW:      wave1 = saw_w;
            mwg_pkg::WAVE_INV_SAW:  wave1 = -saw_w;
            mwg_pkg::WAVE_SQUARE:   wave1 = sq_w;
            mwg_pkg::WAVE_NOISE:    wave1 = noise_w;
            default:                wave1 = '0;
        endcase
    end

    always_comb begin
        neg    = r1_deg > mwg_pkg::DEG_180;
        deg_h  = neg ? (r1_deg - mwg_pkg::DEG_180) : r1_deg;
        deg_q  = (deg_h > mwg_pkg::DEG_90) ? (mwg_pkg::DEG_180 - deg_h) : deg_h;
        idx    = deg_q[PB+mwg_pkg::IDX_W-1:PB];
        full   = idx >= mwg_pkg::IDX_LAST;
        idx_hi = full ? mwg_pkg::IDX_LAST : (idx + mwg_pkg::IDX_W'(1));
        tbl_lo = mwg_pkg::QUARTER_SINE[full ? mwg_pkg::IDX_LAST : idx];
        tbl_hi = mwg_pkg::QUARTER_SINE[idx_hi];
    end

    always_comb begin
        interp_p = (2 * mwg_pkg::TBL_W)'(r2_diff) * (2 * mwg_pkg::TBL_W)'(r2_frac);
        interp   = r2_lo + interp_p[2*mwg_pkg::TBL_W-1:mwg_pkg::TBL_W];
        sine_val = r2_full ? mwg_pkg::QUARTER_SINE[mwg_pkg::IDX_LAST] : interp;
        sine_sh  = sine_val >> (mwg_pkg::TBL_FRAC_W - FB);
        sine_mag = $signed(sine_sh[WW-1:0]);
        if (i_cfg.wave_type == mwg_pkg::WAVE_SINE) begin
            wave3 = r2_neg ? -sine_mag : sine_mag;
        end else begin
            wave3 = r2_wave;
        end
    end

    always_comb begin
        active  = i_cfg.wave_type <= mwg_pkg::WAVE_NOISE;
        sum     = mwg_pkg::SUM_W'(r3_wave) + mwg_pkg::SUM_W'($signed(i_cfg.bias));
        prod    = mwg_pkg::PROD_W'(sum) * mwg_pkg::PROD_W'($signed({1'b0, i_cfg.half_amp}));
        prod_sh = prod >>> FB;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r1_valid    <= o_pop;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r_out_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_deg   <= deg;
            r1_wave  <= wave1[WW-1:0];
            r2_neg   <= neg;
            r2_full  <= full;
            r2_lo    <= tbl_lo;
            r2_diff  <= tbl_hi - tbl_lo;
            r2_frac  <= deg_q[PB-1:PB-mwg_pkg::INTERP_W];
            r2_wave  <= r1_wave;
            r3_wave  <= wave3;
            r_sample <= active ? prod_sh[mwg_pkg::SAMPLE_W-1:0] : '0;
        end
    end

endmodule

/* rtl/core/multi_waveform_generator.sv */
// Direct digital synthesis function generator. Each input beat (with an optional
// restart that clears the phase first) yields one output beat holding one signed
// Q11.12 sample, (wave + bias) * half_amplitude, built from the phase before the
// beat; the phase then advances by phase_step. The front stage updates the phase
// accumulator and, for noise, the xorshift noise state, and can take a beat every
// cycle while the queue has room; a four-entry queue feeds a four-stage back
// pipeline (degree scaling, folding and table lookup, interpolation, gain) that
// delivers one sample per cycle unless output stalls. Up to eight beats can be in
// flight before the input side stalls. The user must write registers through the
// plain write port only while no beat is in flight; the block does not enforce
// it. A wave_type write clears the phase and a seed write reloads the noise state.
module multi_waveform_generator (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [mwg_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [mwg_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_restart,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [mwg_pkg::SAMPLE_W-1:0]   o_sample
);

    mwg_pkg::t_cfg      cfg;
    mwg_pkg::t_item     push_item;
    mwg_pkg::t_item     head_item;
    mwg_pkg::t_q_status q_status;
    logic               push;
    logic               pop;

    mwg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_restart   (i_restart),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_item      (push_item),
        .o_cfg       (cfg)
    );

    mwg_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (push_item),
        .i_pop    (pop),
        .o_item   (head_item),
        .o_status (q_status)
    );

    mwg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_item      (head_item),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_sample    (o_sample)
    );

`ifndef ASSERT_OFF
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.count <= mwg_pkg::QCNT_W'(mwg_pkg::QUEUE_DEPTH))
        else $error("queue fill count above depth");

    a_queue_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty together");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_status.empty)
        else $error("queue popped while empty");

    a_reset_quiet: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");
`endif

endmodule
